FILE: hdl/dsfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfb_pkg
// Shared types and constants of the DLE stuffed frame builder.
// ----------------------------------------------------------------------------

package dsfb_pkg;

	// Framing bytes.
	localparam logic [7:0] DLE_CHAR = 8'h10;
	localparam logic [7:0] STX_CHAR = 8'h02;
	localparam logic [7:0] ETX_CHAR = 8'h03;

	// Frame length field is the payload length plus the two length bytes.
	localparam logic [15:0] LEN_OFFSET = 16'd2;

	// Job queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// One classified payload word, as handed from the front to the back part.
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] frame_len;
		logic [15:0] checksum;
	} job_t;

endpackage

`default_nettype wire

FILE: hdl/dsfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfb_front
// Accepts payload words, keeps the running checksum and builds frame jobs.
// ----------------------------------------------------------------------------

module dsfb_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   data_byte,
	input  wire logic         first_byte,
	input  wire logic         last_byte,
	input  wire logic [15:0]  message_length,
	output dsfb_pkg::job_t    job
);

	logic [15:0] sum_q;
	logic [15:0] sum_next;

	// A first word restarts the sum.
	assign sum_next = (first_byte ? 16'd0 : sum_q) + {8'd0, data_byte};

	always_comb begin
		job.data      = data_byte;
		job.first     = first_byte;
		job.last      = last_byte;
		job.frame_len = message_length + dsfb_pkg::LEN_OFFSET;
		job.checksum  = sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= last_byte ? 16'd0 : sum_next;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/dsfb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfb_queue
// Short first-in first-out queue of frame jobs between front and back.
// ----------------------------------------------------------------------------

module dsfb_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire dsfb_pkg::job_t wr_job,
	output logic              full,
	input  wire logic         rd_en,
	output dsfb_pkg::job_t    rd_job,
	output logic              rd_valid
);

	dsfb_pkg::job_t                   slot_q [dsfb_pkg::QUEUE_DEPTH];
	logic [dsfb_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [dsfb_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [dsfb_pkg::QUEUE_CW-1:0]    count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full     = (count_q == dsfb_pkg::QUEUE_CW'(dsfb_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/dsfb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsfb_back
// Walks each frame job through its output bytes, doubling DLE bytes in stuffed fields.
// ----------------------------------------------------------------------------

module dsfb_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dsfb_pkg::job_t job,
	input  wire logic         job_valid,
	output logic              job_done,
	output logic [7:0]        out_byte,
	output logic              frame_end,
	output logic              empty,
	input  wire logic         pop
);

	typedef enum logic [3:0] {
		ST_START,
		ST_DLE_OPEN,
		ST_STX,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_DATA,
		ST_SUM_HI,
		ST_SUM_LO,
		ST_DLE_CLOSE,
		ST_ETX
	} step_t;

	step_t       step_q;
	step_t       cur_step;
	step_t       next_step;
	logic        dup_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;
	logic [7:0]  cur_byte;
	logic        cur_stuff;
	logic        cur_end;
	logic        advance;
	logic        repeat_byte;
	logic        job_last_step;

	// The output register frees up when it is empty or being popped.
	assign advance = job_valid && (!out_valid_q || pop);

	always_comb begin
		if (step_q == ST_START) begin
			cur_step = job.first ? ST_DLE_OPEN : ST_DATA;
		end else begin
			cur_step = step_q;
		end

		cur_byte      = dsfb_pkg::DLE_CHAR;
		cur_stuff     = 1'b0;
		cur_end       = 1'b0;
		next_step     = ST_START;
		job_last_step = 1'b0;

		case (cur_step)
			ST_DLE_OPEN: begin
				cur_byte  = dsfb_pkg::DLE_CHAR;
				next_step = ST_STX;
			end
			ST_STX: begin
				cur_byte  = dsfb_pkg::STX_CHAR;
				next_step = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				cur_byte  = job.frame_len[15:8];
				cur_stuff = 1'b1;
				next_step = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				cur_byte  = job.frame_len[7:0];
				cur_stuff = 1'b1;
				next_step = ST_DATA;
			end
			ST_DATA: begin
				cur_byte  = job.data;
				cur_stuff = 1'b1;
				if (job.last) begin
					next_step = ST_SUM_HI;
				end else begin
					next_step     = ST_START;
					job_last_step = 1'b1;
				end
			end
			ST_SUM_HI: begin
				cur_byte  = job.checksum[15:8];
				cur_stuff = 1'b1;
				next_step = ST_SUM_LO;
			end
			ST_SUM_LO: begin
				cur_byte  = job.checksum[7:0];
				cur_stuff = 1'b1;
				next_step = ST_DLE_CLOSE;
			end
			ST_DLE_CLOSE: begin
				cur_byte  = dsfb_pkg::DLE_CHAR;
				next_step = ST_ETX;
			end
			ST_ETX: begin
				cur_byte      = dsfb_pkg::ETX_CHAR;
				cur_end       = 1'b1;
				next_step     = ST_START;
				job_last_step = 1'b1;
			end
			default: begin
				cur_byte  = dsfb_pkg::DLE_CHAR;
				next_step = ST_START;
			end
		endcase
	end

	// A DLE in stuffed fields goes out once more before the step moves on.
	assign repeat_byte = cur_stuff && (cur_byte == dsfb_pkg::DLE_CHAR) && !dup_q;
	assign job_done    = advance && job_last_step && !repeat_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_START;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
			out_byte_q  <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= cur_byte;
				frame_end_q <= cur_end;
				if (repeat_byte) begin
					dup_q  <= 1'b1;
					step_q <= cur_step;
				end else begin
					dup_q  <= 1'b0;
					step_q <= next_step;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign empty     = !out_valid_q;

	// The closing flag only ever marks an ETX byte.
	a_end_is_etx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_end_q) |-> (out_byte_q == dsfb_pkg::ETX_CHAR))
		else $error("frame_end set on a byte other than ETX");

	// While a doubled DLE is pending, the first copy sits in the output register.
	a_dup_holds_dle: assert property (@(posedge clk) disable iff (!arst_n)
		dup_q |-> (out_valid_q && out_byte_q == dsfb_pkg::DLE_CHAR))
		else $error("stuffing pending without a DLE in the output register");

	// A job is only retired with a job present and the output register free.
	a_done_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |-> (job_valid && (!out_valid_q || pop)))
		else $error("job retired without a free output slot");

endmodule

`default_nettype wire

FILE: hdl/dle_stuffed_frame_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dle_stuffed_frame_builder
// Builds DLE/STX ... DLE/ETX link frames with byte stuffing from payload words.
// ----------------------------------------------------------------------------
// Words are registered in the job queue, their bytes then in the output register.
// Throughput: one output word per cycle while pop frees the output register;
// a payload word gives one or two output words normally, up to fourteen.
// The output byte sequencer sets the rate; a four-entry job queue buffers bursts.
// Reset: arst_n clears the checksum, the queue and the output register at once.
// ----------------------------------------------------------------------------

module dle_stuffed_frame_builder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [7:0]   data_byte,
	input  wire logic         first_byte,
	input  wire logic         last_byte,
	input  wire logic [15:0]  message_length,
	output logic              empty,
	input  wire logic         pop,
	output logic [7:0]        out_byte,
	output logic              frame_end
);

	// The front part classifies each accepted word into a job that carries
	// everything the back part needs: the data, the frame markers, the frame
	// length field and the checksum including this word.
	dsfb_pkg::job_t front_job;
	dsfb_pkg::job_t head_job;
	logic           accept;
	logic           head_valid;
	logic           head_done;

	assign accept = push && !full;

	dsfb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.message_length (message_length),
		.job            (front_job)
	);

	// The queue lets the input side keep going while the back part is busy
	// sending the header or trailer of a frame, and vice versa.
	dsfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_job   (front_job),
		.full     (full),
		.rd_en    (head_done),
		.rd_job   (head_job),
		.rd_valid (head_valid)
	);

	// The back part steps through the bytes of the job at the queue head and
	// retires it once its final byte has been loaded into the output register.
	dsfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (head_valid),
		.job_done  (head_done),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DLE stuffed frame builder. It pushes payload
// words (a short directed table first, then random messages), works out the
// stuffed link bytes each word should produce and checks every popped word
// against them in order.
// ----------------------------------------------------------------------------

module tb_top;

	// Random payload words to push after the directed table.
	localparam int unsigned RANDOM_WORDS = 320;
	// Length of the one long stall on the output side.
	localparam int unsigned HOLD_CYCLES  = 120;
	// Quiet cycles after the last expected word, to catch stray output words.
	localparam int unsigned DRAIN_CYCLES = 20;

	// One payload word as it is presented on the input ports.
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] length;
	} payload_word_t;

	// One stuffed link byte as it should appear on the output ports.
	typedef struct packed {
		logic [7:0] value;
		logic       closing;
	} link_byte_t;

	// A row of the directed table. Where typed_cnt is not zero, the expected
	// link bytes are taken from typed_link_bytes rather than worked out.
	typedef struct packed {
		payload_word_t word;
		logic [3:0]    typed_cnt;
	} directed_row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        push           = 1'b0;
	logic [7:0]  data_byte      = 8'h00;
	logic        first_byte     = 1'b0;
	logic        last_byte      = 1'b0;
	logic [15:0] message_length = 16'h0000;
	logic        pop            = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic        frame_end;

	// Link bytes still owed by the block, oldest first.
	link_byte_t    pending_link_bytes[$];
	// Our own copy of the checksum that the block keeps over the payload.
	logic [15:0]   payload_sum = 16'h0000;
	int unsigned   mismatch_count = 0;
	int unsigned   random_sent = 0;
	// While set, neither side inserts any idle cycles.
	bit            steady_phase = 1'b0;
	// Raised by the sender to ask the receiver for one long stall.
	bit            hold_request = 1'b0;

	always #2 clk = ~clk;

	dle_stuffed_frame_builder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.message_length (message_length),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.frame_end      (frame_end)
	);

	// Directed table. The first four rows have their link bytes typed in:
	// a lone 0x10 with no frame open, a closing byte on that unframed run, a
	// one-byte frame whose length field wraps round to 0x0001, and a one-byte
	// frame where all stuffable bytes but the checksum high byte are 0x10. The
	// rest are checked against the predictor and cover a frame of length zero,
	// a restart part way through a message, a length field that disagrees with
	// the byte count, and a byte without a start after a frame has closed.
	directed_row_t directed_rows [18] = '{
		'{'{8'h10, 1'b0, 1'b0, 16'h0000}, 4'd2},
		'{'{8'hff, 1'b0, 1'b1, 16'h0000}, 4'd5},
		'{'{8'h10, 1'b1, 1'b1, 16'hffff}, 4'd11},
		'{'{8'h10, 1'b1, 1'b1, 16'h100e}, 4'd13},
		'{'{8'h00, 1'b1, 1'b0, 16'h0000}, 4'd0},
		'{'{8'hff, 1'b0, 1'b0, 16'h0000}, 4'd0},
		'{'{8'h10, 1'b0, 1'b0, 16'h0000}, 4'd0},
		'{'{8'h55, 1'b0, 1'b1, 16'h0000}, 4'd0},
		'{'{8'haa, 1'b1, 1'b0, 16'h0020}, 4'd0},
		'{'{8'h01, 1'b0, 1'b0, 16'hffff}, 4'd0},
		'{'{8'h7f, 1'b1, 1'b0, 16'hfffe}, 4'd0},
		'{'{8'h80, 1'b0, 1'b0, 16'h5a5a}, 4'd0},
		'{'{8'h03, 1'b0, 1'b1, 16'h0000}, 4'd0},
		'{'{8'h02, 1'b1, 1'b0, 16'h0005}, 4'd0},
		'{'{8'h10, 1'b0, 1'b1, 16'h0000}, 4'd0},
		'{'{8'hff, 1'b1, 1'b1, 16'h00ff}, 4'd0},
		'{'{8'h00, 1'b0, 1'b0, 16'ha5a5}, 4'd0},
		'{'{8'h00, 1'b0, 1'b1, 16'h0000}, 4'd0}
	};

	// Expected link bytes of the typed rows above, in row order.
	logic [7:0] typed_link_bytes[$] = '{
		8'h10, 8'h10,
		8'hff, 8'h01, 8'h0f, 8'h10, 8'h03,
		8'h10, 8'h02, 8'h00, 8'h01, 8'h10, 8'h10, 8'h00, 8'h10, 8'h10, 8'h10, 8'h03,
		8'h10, 8'h02, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h00, 8'h10, 8'h10,
		8'h10, 8'h03
	};

	// Idle cycles before the next word on either side: mostly none, often a
	// few, now and then a long pause.
	function automatic int unsigned idle_gap();
		int unsigned roll;
		if (steady_phase)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Payload bytes lean towards the framing characters so that stuffing
	// and look-alike bytes turn up often.
	function automatic logic [7:0] random_payload_byte();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return dsfb_pkg::DLE_CHAR;
		if (roll < 20)
			return ($urandom_range(0, 1) != 0) ? dsfb_pkg::ETX_CHAR : dsfb_pkg::STX_CHAR;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_link(input logic [7:0] value, input logic closing,
			input bit emit);
		if (emit)
			pending_link_bytes.push_back('{value: value, closing: closing});
	endfunction

	// A DLE character inside the frame body goes out twice.
	function automatic void put_stuffed(input logic [7:0] value, input bit emit);
		put_link(value, 1'b0, emit);
		if (value == dsfb_pkg::DLE_CHAR)
			put_link(value, 1'b0, emit);
	endfunction

	// Works out the link bytes that one accepted payload word produces and
	// keeps the running checksum up to date. With emit clear only the
	// checksum moves, for rows whose link bytes are typed in.
	function automatic void build_link_bytes(input payload_word_t w, input bit emit);
		logic [15:0] frame_len;
		if (w.first) begin
			// A start marker opens a new frame, even over an unfinished one.
			frame_len = w.length + dsfb_pkg::LEN_OFFSET;
			payload_sum = 16'h0000;
			put_link(dsfb_pkg::DLE_CHAR, 1'b0, emit);
			put_link(dsfb_pkg::STX_CHAR, 1'b0, emit);
			put_stuffed(frame_len[15:8], emit);
			put_stuffed(frame_len[7:0], emit);
		end
		payload_sum = payload_sum + {8'h00, w.data};
		put_stuffed(w.data, emit);
		if (w.last) begin
			put_stuffed(payload_sum[15:8], emit);
			put_stuffed(payload_sum[7:0], emit);
			put_link(dsfb_pkg::DLE_CHAR, 1'b0, emit);
			put_link(dsfb_pkg::ETX_CHAR, 1'b1, emit);
			payload_sum = 16'h0000;
		end
	endfunction

	// Offers one payload word, starting and ending on a falling edge. The
	// word is taken at the first rising edge at which full is low, and its
	// link bytes are queued at that same edge.
	task automatic send_payload_word(input payload_word_t w, input int unsigned typed_cnt);
		int unsigned gap;
		logic [7:0]  value;
		gap = idle_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push           <= 1'b1;
		data_byte      <= w.data;
		first_byte     <= w.first;
		last_byte      <= w.last;
		message_length <= w.length;
		do @(posedge clk); while (full);
		build_link_bytes(w, typed_cnt == 0);
		for (int unsigned k = 0; k < typed_cnt; k++) begin
			value = typed_link_bytes.pop_front();
			pending_link_bytes.push_back('{value: value,
				closing: w.last && (k == typed_cnt - 1)});
		end
		@(negedge clk);
	endtask

	// Called on a falling edge with push already low; returns on a falling
	// edge once every expected link byte has been popped.
	task automatic wait_until_drained();
		while (pending_link_bytes.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One random message, or a piece of noise. Most are proper frames with
	// random content; the rest are stray bytes, messages cut short by the
	// next start marker, and length fields that do not match the byte count.
	task automatic send_random_message();
		payload_word_t w;
		int unsigned   roll;
		int unsigned   n_bytes;
		int unsigned   stop_at;
		logic [15:0]   length;
		bit            abandon;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			w.data   = random_payload_byte();
			w.first  = 1'b0;
			w.last   = 1'($urandom_range(0, 1));
			w.length = 16'($urandom_range(0, 65535));
			send_payload_word(w, 0);
			random_sent++;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 15)
				n_bytes = 1;
			else if (roll < 80)
				n_bytes = $urandom_range(2, 8);
			else
				n_bytes = $urandom_range(32, 60);  // full header plus a body
			roll = $urandom_range(0, 99);
			if (roll < 80)
				length = 16'(n_bytes);
			else if (roll < 90)
				length = 16'($urandom_range(0, 65535));
			else begin
				case ($urandom_range(0, 2))
					0: length = 16'hffff;
					1: length = 16'hfffe;
					default: length = 16'h0000;
				endcase
			end
			abandon = ($urandom_range(0, 99) < 10);
			stop_at = abandon ? $urandom_range(1, n_bytes) : n_bytes;
			for (int unsigned i = 0; i < stop_at; i++) begin
				w.data   = random_payload_byte();
				w.first  = (i == 0);
				w.last   = !abandon && (i == n_bytes - 1);
				// The length is only read with the first byte; elsewhere it is noise.
				w.length = (i == 0) ? length : 16'($urandom_range(0, 65535));
				send_payload_word(w, 0);
			end
			random_sent += stop_at;
		end
	endtask

	// Sender: reset, the directed table, a full drain, then random messages
	// with one long output stall and one mid-run drain, and the final check.
	initial begin : payload_sender
		bit hold_asked;
		bit mid_drain_done;
		hold_asked     = 1'b0;
		mid_drain_done = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			send_payload_word(directed_rows[r].word, directed_rows[r].typed_cnt);
		push <= 1'b0;
		wait_until_drained();

		while (random_sent < RANDOM_WORDS) begin
			// The receiver stalls for a long stretch while we keep pushing, so
			// the job queue fills and full has to hold us off.
			if (random_sent >= 80 && !hold_asked) begin
				hold_asked   = 1'b1;
				hold_request = 1'b1;
			end
			// Part way through, stop and let every owed byte come out.
			if (random_sent >= 160 && !mid_drain_done) begin
				mid_drain_done = 1'b1;
				push <= 1'b0;
				wait_until_drained();
			end
			steady_phase = (random_sent >= 220 && random_sent < 270);
			send_random_message();
		end
		steady_phase = 1'b0;
		push <= 1'b0;
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: checks each popped word against the oldest expected link
	// byte, then decides how long to leave pop low before the next one.
	initial begin : link_receiver
		int unsigned idle_left;
		link_byte_t  want;
		idle_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_link_bytes.size() == 0) begin
					$error("unexpected word: out_byte %h, frame_end %b", out_byte, frame_end);
					mismatch_count++;
				end else begin
					want = pending_link_bytes.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %h, got %h", want.value, out_byte);
						mismatch_count++;
					end
					if (frame_end !== want.closing) begin
						$error("frame_end: expected %b, got %b", want.closing, frame_end);
						mismatch_count++;
					end
				end
				idle_left = idle_gap();
			end
			if (hold_request) begin
				hold_request = 1'b0;
				idle_left    = HOLD_CYCLES;
			end
			@(negedge clk);
			if (idle_left != 0) begin
				pop <= 1'b0;
				idle_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog, well beyond the slowest correct run.
	initial begin : run_watchdog
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
